/* rtl/core/intensity_histogram_quartiles_defines.svh */
// ----------------------------------------------------------------------------
// Intensity histogram quartiles: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTENSITY_HISTOGRAM_QUARTILES_DEFINES_SVH
`define INTENSITY_HISTOGRAM_QUARTILES_DEFINES_SVH

// same-cycle implication
`define IHQ_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ihq assertion failed");

// next-cycle implication
`define IHQ_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ihq assertion failed");

`endif

/* rtl/core/ihq_pkg.sv */
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared constants of the intensity histogram quartiles block.
// ----------------------------------------------------------------------------
package ihq_pkg;

  localparam int BIN_COUNT_DEF  = 256;
  localparam int COUNT_BITS_DEF = 21;

  localparam int INTENSITY_W    = 16;
  localparam int SAMPLE_COUNT_W = 21;
  localparam int MEAN_W         = 16;
  localparam int STDDEV_W       = 15;
  localparam int QUANT_W        = 8;
  localparam int FRAC_BITS      = 8;

  localparam int OUT_FIELDS_W   = SAMPLE_COUNT_W + MEAN_W + STDDEV_W + 3 * QUANT_W;
  localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

endpackage

/* rtl/core/ihq_ram.sv */
// ----------------------------------------------------------------------------
// ihq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihq_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ihq_stats.sv */
// ----------------------------------------------------------------------------
// ihq_stats
// Serial arithmetic for mean and deviation: shift-add multiplier,
// restoring divider and bit-pair square root, one step per cycle.
// ----------------------------------------------------------------------------
module ihq_stats #(
  parameter int BIN_COUNT  = ihq_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = ihq_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [COUNT_BITS-1:0]                 n,
  input  logic [COUNT_BITS+$clog2(BIN_COUNT)-1:0]   s1,
  input  logic [COUNT_BITS+2*$clog2(BIN_COUNT)-1:0] s2,
  output logic                                  done,
  output logic [ihq_pkg::MEAN_W-1:0]            mean,
  output logic [ihq_pkg::STDDEV_W-1:0]          stddev
);

  localparam int C   = COUNT_BITS;
  localparam int BB  = $clog2(BIN_COUNT);
  localparam int S1W = C + BB;
  localparam int S2W = C + 2 * BB;
  localparam int MBW = S1W;
  localparam int PW  = S2W + MBW;
  localparam int DDW = 2 * C + 2 * BB;
  localparam int DW  = DDW + 2 * ihq_pkg::FRAC_BITS;
  localparam int DVW = 2 * C + 1;
  localparam int SW  = 2 * BB + 2 * ihq_pkg::FRAC_BITS;
  localparam int CW  = $clog2(DW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_MUL3 = 3'd3;
  localparam logic [2:0] S_DIV1 = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_SQRT = 3'd6;

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  logic [C-1:0]    n_r;
  logic [S1W-1:0]  s1_r;
  logic [PW-1:0]   ma;
  logic [MBW-1:0]  mb;
  logic [PW-1:0]   acc;
  logic [PW-1:0]   m1;
  logic [PW-1:0]   dif;
  logic [DVW-1:0]  nn;
  logic [DW-1:0]   dd;
  logic [DVW-1:0]  dvs;
  logic [DVW-1:0]  rem;
  logic [SW-1:0]   x;
  logic [SW-1:0]   res;
  logic [SW-1:0]   bitr;

  logic [PW-1:0]   acc_step;
  logic [DVW:0]    shl;
  logic            ge;
  logic [DVW-1:0]  rem_step;
  logic [DW-1:0]   dd_step;
  logic [SW-1:0]   sq_t;
  logic            sq_ge;
  logic [SW-1:0]   x_step;
  logic [SW-1:0]   res_step;

  always_comb begin
    acc_step = mb[0] ? acc + ma : acc;
    shl      = {rem, dd[DW-1]};
    ge       = shl >= {1'b0, dvs};
    rem_step = ge ? DVW'(shl - {1'b0, dvs}) : shl[DVW-1:0];
    dd_step  = {dd[DW-2:0], ge};
    sq_t     = res + bitr;
    sq_ge    = x >= sq_t;
    x_step   = sq_ge ? x - sq_t : x;
    res_step = sq_ge ? (res >> 1) + bitr : res >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= start && (n == '0);
          if (start) begin
            n_r  <= n;
            s1_r <= s1;
            if (n == '0) begin
              mean   <= '0;
              stddev <= '0;
            end else begin
              ma    <= PW'(s2);
              mb    <= MBW'(n);
              acc   <= '0;
              cnt   <= '0;
              state <= S_MUL1;
            end
          end
        end
        S_MUL1, S_MUL2, S_MUL3: begin
          done <= 1'b0;
          if (cnt == CW'(MBW - 1)) begin
            acc <= '0;
            cnt <= '0;
            if (state == S_MUL1) begin
              m1    <= acc_step;
              ma    <= PW'(s1_r);
              mb    <= s1_r;
              state <= S_MUL2;
            end else if (state == S_MUL2) begin
              dif   <= m1 - acc_step;
              ma    <= PW'(n_r);
              mb    <= MBW'(n_r);
              state <= S_MUL3;
            end else begin
              nn    <= DVW'(acc_step);
              dd    <= DW'({s1_r, 9'd0} + (S1W + 9)'(n_r));
              dvs   <= DVW'({n_r, 1'b0});
              rem   <= '0;
              state <= S_DIV1;
            end
          end else begin
            acc <= acc_step;
            ma  <= ma << 1;
            mb  <= mb >> 1;
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV1, S_DIV2: begin
          done <= 1'b0;
          if (cnt == CW'(DW - 1)) begin
            cnt <= '0;
            if (state == S_DIV1) begin
              mean  <= dd_step[ihq_pkg::MEAN_W-1:0];
              dd    <= {dif[DDW-1:0], (2 * ihq_pkg::FRAC_BITS)'(0)};
              dvs   <= nn;
              rem   <= '0;
              state <= S_DIV2;
            end else begin
              x     <= dd_step[SW-1:0];
              res   <= '0;
              bitr  <= SW'(1) << (SW - 2);
              state <= S_SQRT;
            end
          end else begin
            dd  <= dd_step;
            rem <= rem_step;
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          x    <= x_step;
          res  <= res_step;
          bitr <= bitr >> 2;
          cnt  <= cnt + 1'b1;
          done <= (cnt == CW'(SW / 2 - 1));
          if (cnt == CW'(SW / 2 - 1)) begin
            stddev <= ihq_pkg::STDDEV_W'(res_step);
            state  <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/intensity_histogram_quartiles.sv */
// ----------------------------------------------------------------------------
// intensity_histogram_quartiles
// Histogram of clamped intensities in RAM; a finish sweeps the bins,
// emits count, mean, deviation and quartiles, and clears the histogram.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser: command; tdata: intensity
//  m_axis    out  tdata: statistics of one finish
//  cfg       in   quantile_fix
//
//  Add: RAM read of the bin, then write of the incremented bin.
//  Finish: sweep over the BIN_COUNT bins, then serial math in ihq_stats.
//  Reset: clearing pass over all bins, no samples taken meanwhile.
//  Adds continue while a result waits on m_tready; a finish sweeps and then
//  holds its result until the output slot is free.
// ----------------------------------------------------------------------------
`include "intensity_histogram_quartiles_defines.svh"

module intensity_histogram_quartiles #(
  parameter int BIN_COUNT  = ihq_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = ihq_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,   // command
  input  logic [ihq_pkg::INTENSITY_W-1:0] s_tdata,   // intensity
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // sample_count[20:0], mean_q8[36:21], stddev_q8[51:37], first_quartile[59:52],
  // median_bin[67:60], third_quartile[75:68], zero fill
  output logic [ihq_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int C   = COUNT_BITS;
  localparam int BB  = $clog2(BIN_COUNT);
  localparam int S1W = C + BB;
  localparam int S2W = C + 2 * BB;
  localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_MATH  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]     state;
  logic           quantile_fix;
  logic [C-1:0]   total;
  logic [BB:0]    rb;
  logic [BB-1:0]  add_bin;
  logic [BB-1:0]  db;
  logic           dv;
  logic           pv;
  logic [C-1:0]   cum;
  logic [2*BB-1:0] sq;
  logic [BB+C-1:0]   p1;
  logic [2*BB+C-1:0] p2;
  logic [S1W-1:0] s1;
  logic [S2W-1:0] s2;
  logic [BB-1:0]  q1;
  logic [BB-1:0]  med;
  logic [BB-1:0]  q3;
  logic           q1f;
  logic           medf;
  logic           q3f;
  logic           math_start;
  logic [C-1:0]   n_hold;

  logic           ram_we;
  logic [BB-1:0]  ram_waddr;
  logic [C-1:0]   ram_wdata;
  logic [BB-1:0]  ram_raddr;
  logic [C-1:0]   ram_rdata;

  logic           in_acc;
  logic [BB-1:0]  in_bin;
  logic [C-1:0]   cum_next;
  logic           h1;
  logic           h2;
  logic           h3;
  logic           issue;
  logic           out_load;

  logic                            math_done;
  logic [ihq_pkg::MEAN_W-1:0]      mean;
  logic [ihq_pkg::STDDEV_W-1:0]    stddev;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign issue    = (rb < (BB + 1)'(BIN_COUNT));
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    if (s_tdata[ihq_pkg::INTENSITY_W-1]) begin
      in_bin = '0;
    end else if (s_tdata > ihq_pkg::INTENSITY_W'(BIN_COUNT - 1)) begin
      in_bin = BB'(BIN_COUNT - 1);
    end else begin
      in_bin = s_tdata[BB-1:0];
    end
    cum_next = cum + ram_rdata;
    h1 = {cum_next, 2'b00} >= (C + 2)'(total);
    h2 = {1'b0, cum_next, 1'b0} >= (C + 2)'(total);
    h3 = {cum_next, 2'b00} >= (C + 2)'({total, 1'b0}) + (C + 2)'(total);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = db;
    ram_wdata = '0;
    ram_raddr = (state == ST_SWEEP) ? rb[BB-1:0] : in_bin;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rb[BB-1:0];
      end
      ST_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = add_bin;
        ram_wdata = ram_rdata + 1'b1;
      end
      ST_SWEEP: begin
        ram_we = dv;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ihq_ram #(
    .WIDTH (C),
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ihq_stats #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk    (clk),
    .rst    (rst),
    .start  (math_start),
    .n      (n_hold),
    .s1     (s1),
    .s2     (s2),
    .done   (math_done),
    .mean   (mean),
    .stddev (stddev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      quantile_fix <= 1'b1;
      total        <= '0;
      rb           <= '0;
      dv           <= 1'b0;
      pv           <= 1'b0;
      math_start   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantile_fix <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      pv <= dv;
      case (state)
        ST_CLEAR: begin
          rb <= rb + 1'b1;
          if (rb == (BB + 1)'(BIN_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tuser == ihq_pkg::CMD_FINISH) begin
              rb    <= '0;
              cum   <= '0;
              sq    <= '0;
              s1    <= '0;
              s2    <= '0;
              q1    <= '0;
              med   <= '0;
              q3    <= '0;
              q1f   <= 1'b0;
              medf  <= 1'b0;
              q3f   <= 1'b0;
              state <= ST_SWEEP;
            end else if (total != COUNT_MAX) begin
              add_bin <= in_bin;
              state   <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          total <= total + 1'b1;
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (issue) begin
            rb <= rb + 1'b1;
          end
          dv <= issue;
          db <= rb[BB-1:0];
          if (dv) begin
            cum <= cum_next;
            sq  <= sq + (2 * BB)'({db, 1'b1});
            p1  <= (BB + C)'(db) * (BB + C)'(ram_rdata);
            p2  <= (2 * BB + C)'(sq) * (2 * BB + C)'(ram_rdata);
            if (!q3f) begin
              if (quantile_fix) begin
                if (!q1f && h1) begin
                  q1  <= db;
                  q1f <= 1'b1;
                end
                if (!medf && h2) begin
                  med  <= db;
                  medf <= 1'b1;
                end
              end else begin
                if (h1 && q1 == '0) begin
                  q1 <= db;
                end
                if (h2 && med == '0) begin
                  med <= db;
                end
              end
              if (h3) begin
                q3  <= db;
                q3f <= 1'b1;
              end
            end
          end
          if (pv) begin
            s1 <= s1 + S1W'(p1);
            s2 <= s2 + S2W'(p2);
          end
          if (!issue && !dv && !pv) begin
            n_hold     <= total;
            total      <= '0;
            math_start <= 1'b1;
            state      <= ST_MATH;
          end
        end
        ST_MATH: begin
          math_start <= 1'b0;
          if (math_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_tdata  <= ihq_pkg::OUT_DATA_W'({
                          ihq_pkg::QUANT_W'(q3),
                          ihq_pkg::QUANT_W'(med),
                          ihq_pkg::QUANT_W'(q1),
                          stddev,
                          mean,
                          ihq_pkg::SAMPLE_COUNT_W'(n_hold)});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IHQ_ASSERT_NXT(a_add_writes, in_acc && s_tuser == ihq_pkg::CMD_ADD && total != COUNT_MAX, ram_we)
  `IHQ_ASSERT_NXT(a_finish_sweeps, state == ST_IDLE && in_acc && s_tuser == ihq_pkg::CMD_FINISH && !m_tvalid, state == ST_SWEEP && !s_tready)
  `IHQ_ASSERT_IMP(a_done_in_math, math_done, state == ST_MATH)

endmodule
